[design/pibc_pkg.sv]
// Shared widths, codes and operand types of the PI back-calculation regulator.
package pibc_pkg;

  localparam int FRAC_W   = 12;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 16;
  localparam int OUT_W    = 24;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int ACC_W    = 29;
  localparam int SAT_W    = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Shared multiplier: signed 25 x signed 18 gives a 43 bit product.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_MODE = 3'd0,
    CFG_PROP_GAIN    = 3'd1,
    CFG_INTEG_GAIN   = 3'd2,
    CFG_OUT_LOW      = 3'd3,
    CFG_OUT_HIGH     = 3'd4
  } cfg_idx_e;

  // Request operation codes.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

[design/pibc_ifs.sv]
// Valid/ready channel interfaces: sample requests, results and register writes.
interface pibc_sample_if import pibc_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [SAMPLE_W-1:0] setpoint;
  logic signed [SAMPLE_W-1:0] feedback;

  modport source (output valid, operation, setpoint, feedback, input ready);
  modport sink   (input valid, operation, setpoint, feedback, output ready);
endinterface

interface pibc_result_if import pibc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_value;
  logic                    limited;

  modport source (output valid, out_value, limited, input ready);
  modport sink   (input valid, out_value, limited, output ready);
endinterface

interface pibc_cfg_if import pibc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/pibc_mul.sv]
// Shared signed multiplier with a registered product.
module pibc_mul import pibc_pkg::*; (
  input  logic                     clk,
  input  mul_op_t                  op,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op.a * op.b);
  end

endmodule

[design/pi_backcalc_antiwindup.sv]
// Top level of the PI regulator with back-calculation anti-windup.
//
// Channels:
//   sample - request with operation, setpoint and feedback (valid/ready).
//            An update request runs the regulator once; a clear request
//            zeroes the integral and the stored saturation excess.
//   result - one result per request: out_value and limited (valid/ready).
//   cfg    - register writes (index, data); always ready. Write only while
//            no request is in flight and the last result has left.
// Sequence:
//   An update request runs through seven sequencer steps around one shared
//   25x18 multiplier (proportional product, difference, low and high halves
//   of the integral product, accumulate, integral clamp, output). The result
//   register loads in the output step. A clear request goes from idle
//   straight to the output step and loads its zero result there.
//   The next request is accepted as soon as the sequencer is back in idle,
//   so no new request is taken until the last one has loaded its result.
// Stalls: a finished result waits in the output register; if the receiver
//   still holds the previous one, the sequencer holds in its last step.
// Reset: synchronous, active high. Clears the state, the output valid and
//   sets the registers to speed mode, zero gains and full 16 bit limits.
module pi_backcalc_antiwindup import pibc_pkg::*; (
  input logic          clk,
  input logic          rst,
  pibc_cfg_if.sink     cfg,
  pibc_sample_if.sink  sample,
  pibc_result_if.source result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_P,
    S_DIFF,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_CLAMP,
    S_FIN
  } state_t;

  localparam int P_W = 34;            // kp * err, 12 fraction bits
  localparam int D_W = SAT_W + 1;     // p - sat_excess
  localparam int T_W = 48;            // integral before clamp
  localparam int U_W = P_W + 1;       // unclamped output
  localparam int LO_W = 24;           // low half of the difference

  state_t state;

  // Configuration registers.
  logic                      current_mode;
  logic [GAIN_W-1:0]         prop_gain;
  logic [GAIN_W-1:0]         integ_gain;
  logic signed [LIMIT_W-1:0] out_low;
  logic signed [LIMIT_W-1:0] out_high;

  // Regulator state.
  logic signed [ACC_W-1:0] integral_acc;
  logic signed [SAT_W-1:0] sat_excess;

  // Working registers.
  logic                    clear_op;
  logic signed [ERR_W-1:0] err;
  logic signed [P_W-1:0]   p_term;
  logic signed [D_W-1:0]   diff;
  logic signed [T_W-1:0]   integ_sum;
  logic signed [U_W-1:0]   unclamped;

  mul_op_t                  mul_op;
  logic signed [PROD_W-1:0] prod;

  pibc_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  // Select multiplier operands for the current step.
  always_comb begin
    mul_op = '0;
    unique case (state)
      S_MUL_P: begin
        mul_op.a = MUL_A_W'(err);
        mul_op.b = $signed({2'b00, prop_gain});
      end
      S_MUL_LO: begin
        mul_op.a = $signed({1'b0, diff[LO_W-1:0]});
        mul_op.b = $signed({2'b00, integ_gain});
      end
      S_MUL_HI: begin
        mul_op.a = $signed({{(MUL_A_W-D_W+LO_W){diff[D_W-1]}}, diff[D_W-1:LO_W]});
        mul_op.b = $signed({2'b00, integ_gain});
      end
      default: mul_op = '0;
    endcase
  end

  logic signed [ERR_W-1:0] err_next;
  logic signed [D_W-1:0]   diff_next;
  logic signed [T_W-1:0]   lo_term;
  logic signed [T_W-1:0]   hi_term;
  logic [LIMIT_W:0]        lo_abs;
  logic [LIMIT_W:0]        hi_abs;
  logic [LIMIT_W:0]        lim_abs;
  logic signed [T_W-1:0]   imax_pos;
  logic signed [T_W-1:0]   imax_neg;
  logic signed [ACC_W-1:0] integ_next;
  logic signed [U_W-1:0]   hi_fix;
  logic signed [U_W-1:0]   lo_fix;
  logic signed [U_W-1:0]   clamped;
  logic                    speed_lim;
  logic signed [OUT_W-1:0] value_next;
  logic                    limited_next;
  logic                    out_load;

  assign err_next = $signed({sample.setpoint[SAMPLE_W-1], sample.setpoint})
                  - $signed({sample.feedback[SAMPLE_W-1], sample.feedback});

  // The product register holds kp * err here.
  assign diff_next = D_W'($signed(prod[P_W-1:0])) - D_W'(sat_excess);

  // Low half product is non-negative; take its floor at 12 fraction bits.
  assign lo_term = $signed({{(T_W-(GAIN_W+LO_W-FRAC_W)){1'b0}},
                            prod[GAIN_W+LO_W-1:FRAC_W]});
  // High half carries weight 2^24, i.e. 2^12 at 12 fraction bits.
  assign hi_term = $signed({{(T_W-P_W-FRAC_W){prod[P_W-1]}}, prod[P_W-1:0],
                            {FRAC_W{1'b0}}});

  // Integral limit: max(|out_low|, |out_high|) in 12 fraction bits.
  assign lo_abs  = out_low[LIMIT_W-1] ? ((LIMIT_W+1)'(0) - {1'b1, out_low})
                                      : {1'b0, out_low};
  assign hi_abs  = out_high[LIMIT_W-1] ? ((LIMIT_W+1)'(0) - {1'b1, out_high})
                                       : {1'b0, out_high};
  assign lim_abs = (lo_abs > hi_abs) ? lo_abs : hi_abs;
  assign imax_pos = $signed({{(T_W-LIMIT_W-1-FRAC_W){1'b0}}, lim_abs,
                             {FRAC_W{1'b0}}});
  assign imax_neg = -imax_pos;

  always_comb begin
    if (integ_sum > imax_pos) begin
      integ_next = imax_pos[ACC_W-1:0];
    end else if (integ_sum < imax_neg) begin
      integ_next = imax_neg[ACC_W-1:0];
    end else begin
      integ_next = integ_sum[ACC_W-1:0];
    end
  end

  // Output stage. In current mode the floor of the unclamped value always
  // fits the 24 bit field, so no saturation ever occurs there.
  assign hi_fix = $signed({{(U_W-LIMIT_W-FRAC_W){out_high[LIMIT_W-1]}}, out_high,
                           {FRAC_W{1'b0}}});
  assign lo_fix = $signed({{(U_W-LIMIT_W-FRAC_W){out_low[LIMIT_W-1]}}, out_low,
                           {FRAC_W{1'b0}}});

  always_comb begin
    if (unclamped > hi_fix) begin
      clamped   = hi_fix;
      speed_lim = 1'b1;
    end else if (unclamped < lo_fix) begin
      clamped   = lo_fix;
      speed_lim = 1'b1;
    end else begin
      clamped   = unclamped;
      speed_lim = 1'b0;
    end
  end

  always_comb begin
    if (clear_op == OP_CLEAR) begin
      value_next   = '0;
      limited_next = 1'b0;
    end else if (current_mode) begin
      value_next   = OUT_W'($signed(unclamped[U_W-1:FRAC_W]));
      limited_next = 1'b0;
    end else begin
      value_next   = OUT_W'($signed(clamped[FRAC_W+LIMIT_W-1:FRAC_W]));
      limited_next = speed_lim;
    end
  end

  assign out_load     = (state == S_FIN) && (!result.valid || result.ready);
  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
      current_mode <= 1'b0;
      prop_gain    <= '0;
      integ_gain   <= '0;
      out_low      <= {1'b1, {(LIMIT_W-1){1'b0}}};
      out_high     <= {1'b0, {(LIMIT_W-1){1'b1}}};
      integral_acc <= '0;
      sat_excess   <= '0;
    end else begin
      // Register writes; indexes beyond the list are dropped.
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_CURRENT_MODE: current_mode <= cfg.data[0];
          CFG_PROP_GAIN:    prop_gain    <= cfg.data;
          CFG_INTEG_GAIN:   integ_gain   <= cfg.data;
          CFG_OUT_LOW:      out_low      <= $signed(cfg.data);
          CFG_OUT_HIGH:     out_high     <= $signed(cfg.data);
          default: ;
        endcase
      end

      // Retire a delivered result unless a new one replaces it.
      if (result.valid && result.ready && !out_load) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            clear_op <= sample.operation;
            err      <= err_next;
            state    <= (sample.operation == OP_CLEAR) ? S_FIN : S_MUL_P;
          end
        end
        S_MUL_P: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          p_term <= prod[P_W-1:0];
          diff   <= diff_next;
          state  <= S_MUL_LO;
        end
        S_MUL_LO: begin
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          integ_sum <= T_W'(integral_acc) + lo_term;
          state     <= S_ACC;
        end
        S_ACC: begin
          integ_sum <= integ_sum + hi_term;
          state     <= S_CLAMP;
        end
        S_CLAMP: begin
          integral_acc <= integ_next;
          unclamped    <= U_W'(p_term) + U_W'(integ_next);
          state        <= S_FIN;
        end
        S_FIN: begin
          // Hold until the output register is free.
          if (out_load) begin
            result.valid     <= 1'b1;
            result.out_value <= value_next;
            result.limited   <= limited_next;
            if (clear_op == OP_CLEAR) begin
              integral_acc <= '0;
              sat_excess   <= '0;
            end else if (!current_mode) begin
              sat_excess <= SAT_W'(unclamped - clamped);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The integral never leaves +/- 2^27 (the largest possible limit).
  a_integral_range: assert property (@(posedge clk) disable iff (rst)
    (integral_acc <= $signed(ACC_W'(1 << 27))) &&
    (integral_acc >= -$signed(ACC_W'(1 << 27))))
    else $error("integral accumulator outside its clamp range");

  // In speed mode a result is flagged exactly when an excess was recorded.
  a_excess_flag: assert property (@(posedge clk) disable iff (rst)
    (out_load && !current_mode) |=> (result.limited == (sat_excess != '0)))
    else $error("limited flag disagrees with recorded excess");

  // An accepted request leaves the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sequencer still ready after accepting a request");

endmodule

[tb/sv/pi_backcalc_antiwindup_tb.sv]
// Self-checking testbench for the PI regulator with back-calculation anti-windup.
module pi_backcalc_antiwindup_tb;
  import pibc_pkg::*;

  // One result as the block returns it.
  typedef struct packed {
    logic signed [OUT_W-1:0] out_value;
    logic                    limited;
  } result_t;

  localparam longint OUT_TOP    = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_BOTTOM = -(longint'(1) <<< (OUT_W - 1));

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  pibc_cfg_if    cfg_ch ();
  pibc_sample_if smp_ch ();
  pibc_result_if res_ch ();

  pi_backcalc_antiwindup dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (smp_ch),
    .result (res_ch)
  );

  // Register mirror, kept in step with every accepted write.
  logic                      mode_q;
  logic [GAIN_W-1:0]         kp_q;
  logic [GAIN_W-1:0]         ki_q;
  logic signed [LIMIT_W-1:0] lo_q;
  logic signed [LIMIT_W-1:0] hi_q;

  // Regulator state with 12 fraction bits, as the block holds it.
  longint integ_acc;
  longint excess_acc;

  result_t pending_outputs[$];
  int      error_count = 0;
  bit      bursts_on   = 1'b1;
  int      stall_left  = 0;

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Predict one request: advance the integral and the saturation excess and
  // form the result exactly as the fixed-point regulator does.
  function automatic result_t regulate(input logic op,
                                       input logic signed [SAMPLE_W-1:0] sp,
                                       input logic signed [SAMPLE_W-1:0] fb);
    result_t r;
    longint  err, kp, ki, acc, bound, lo_mag, hi_mag, total, held, whole;
    longint  lo_fx, hi_fx;
    r = '0;
    if (op == OP_CLEAR) begin
      integ_acc  = 0;
      excess_acc = 0;
      return r;
    end
    err = longint'(sp) - longint'(fb);
    kp  = longint'(kp_q);
    ki  = longint'(ki_q);
    // Increment carries 24 fraction bits; floor it back to 12.
    acc    = integ_acc + ((kp * ki * err - ki * excess_acc) >>> FRAC_W);
    lo_mag = (lo_q < 0) ? -longint'(lo_q) : longint'(lo_q);
    hi_mag = (hi_q < 0) ? -longint'(hi_q) : longint'(hi_q);
    bound  = ((lo_mag > hi_mag) ? lo_mag : hi_mag) <<< FRAC_W;
    if (acc > bound) acc = bound;
    else if (acc < -bound) acc = -bound;
    integ_acc = acc;
    total = kp * err + acc;
    if (mode_q) begin
      // Current loop: no clamp, only saturation to the output field.
      whole = total >>> FRAC_W;
      if (whole > OUT_TOP) begin
        whole     = OUT_TOP;
        r.limited = 1'b1;
      end else if (whole < OUT_BOTTOM) begin
        whole     = OUT_BOTTOM;
        r.limited = 1'b1;
      end
    end else begin
      // Speed loop: upper limit is tested first, which settles inverted limits.
      lo_fx = longint'(lo_q) <<< FRAC_W;
      hi_fx = longint'(hi_q) <<< FRAC_W;
      if (total > hi_fx) begin
        held      = hi_fx;
        r.limited = 1'b1;
      end else if (total < lo_fx) begin
        held      = lo_fx;
        r.limited = 1'b1;
      end else begin
        held = total;
      end
      excess_acc = total - held;
      whole      = held >>> FRAC_W;
    end
    r.out_value = whole[OUT_W-1:0];
    return r;
  endfunction

  // Result side: take each result, compare it with the oldest prediction and
  // drive ready with random stall bursts while bursts are enabled.
  always @(posedge clk) begin
    result_t want;
    if (res_ch.valid && res_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected result out_value=%0d limited=%0b",
                                  res_ch.out_value, res_ch.limited));
      end else begin
        want = pending_outputs.pop_front();
        if (res_ch.out_value !== want.out_value)
          report_mismatch($sformatf("out_value got %0d want %0d",
                                    res_ch.out_value, want.out_value));
        if (res_ch.limited !== want.limited)
          report_mismatch($sformatf("limited got %0b want %0b (out_value %0d)",
                                    res_ch.limited, want.limited, want.out_value));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 7) == 0) begin
      // Start a stall burst here, this cycle included; stall_left holds the rest.
      stall_left = $urandom_range(0, 10);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Send one request: maybe idle for a burst, then hold valid until accepted.
  // Valid stays high on return so that back-to-back requests never drop it.
  task automatic send_request(input logic op,
                              input logic signed [SAMPLE_W-1:0] sp,
                              input logic signed [SAMPLE_W-1:0] fb);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      smp_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    smp_ch.valid     <= 1'b1;
    smp_ch.operation <= op;
    smp_ch.setpoint  <= sp;
    smp_ch.feedback  <= fb;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    pending_outputs.push_back(regulate(op, sp, fb));
  endtask

  // Drop valid, hold until every result is back, then let the sequencer settle.
  task automatic wait_drained();
    smp_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_CURRENT_MODE: mode_q = value[0];
      CFG_PROP_GAIN:    kp_q   = value;
      CFG_INTEG_GAIN:   ki_q   = value;
      CFG_OUT_LOW:      lo_q   = value;
      CFG_OUT_HIGH:     hi_q   = value;
      default: ;
    endcase
  endtask

  // Write all five registers back to back; only call while drained.
  task automatic set_config(input logic mode, input logic [GAIN_W-1:0] kp,
                            input logic [GAIN_W-1:0] ki,
                            input logic signed [LIMIT_W-1:0] lo,
                            input logic signed [LIMIT_W-1:0] hi);
    write_register(CFG_CURRENT_MODE, {15'd0, mode});
    write_register(CFG_PROP_GAIN, kp);
    write_register(CFG_INTEG_GAIN, ki);
    write_register(CFG_OUT_LOW, lo);
    write_register(CFG_OUT_HIGH, hi);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return GAIN_W'($urandom);
      1:       return GAIN_W'($urandom_range(0, 4095));
      2:       return GAIN_W'($urandom_range(0, 511));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SAMPLE_W'($urandom_range(0, 200)) - 16'd100;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic set_random_config();
    logic signed [LIMIT_W-1:0] lo, hi;
    case ($urandom_range(0, 4))
      0: begin  // full range
        lo = 16'sh8000;
        hi = 16'sh7FFF;
      end
      1: begin  // inverted limits
        lo = LIMIT_W'($urandom_range(0, 20000));
        hi = -LIMIT_W'($urandom_range(0, 20000));
      end
      2: begin  // narrow window, saturates often
        lo = -LIMIT_W'($urandom_range(0, 300));
        hi = LIMIT_W'($urandom_range(0, 300));
      end
      default: begin
        lo = -LIMIT_W'($urandom_range(0, 32768));
        hi = LIMIT_W'($urandom_range(0, 32767));
      end
    endcase
    set_config(logic'($urandom_range(0, 1)), pick_gain(), pick_gain(), lo, hi);
  endtask

  // Reset values: zero gains give zero output, whatever the error.
  task automatic test_reset_values();
    send_request(OP_UPDATE, 16'sh7FFF, 16'sh8000);
    send_request(OP_UPDATE, 16'sh8000, 16'sh7FFF);
  endtask

  // Speed loop at unity proportional gain with the widest error both ways,
  // so the output clamps and the excess feeds back; clear zeroes it all.
  task automatic test_speed_extremes();
    wait_drained();
    set_config(1'b0, 16'h1000, 16'h0200, 16'sh8000, 16'sh7FFF);
    send_request(OP_UPDATE, 16'sh7FFF, 16'sh8000);
    send_request(OP_UPDATE, 16'sh7FFF, 16'sh8000);
    send_request(OP_UPDATE, 16'sh8000, 16'sh7FFF);
    send_request(OP_UPDATE, 16'sd0, 16'sd0);
    send_request(OP_UPDATE, 16'sd100, 16'sd90);
    send_request(OP_CLEAR, 16'sh7FFF, 16'sh8000);
    send_request(OP_UPDATE, 16'sd5, 16'sd0);
  endtask

  // Current loop at full gains: no clamp, only the output field bounds it.
  task automatic test_current_mode();
    wait_drained();
    set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'sh8000, 16'sh7FFF);
    send_request(OP_UPDATE, 16'sh7FFF, 16'sh8000);
    send_request(OP_UPDATE, 16'sh7FFF, 16'sh8000);
    send_request(OP_UPDATE, 16'sh8000, 16'sh7FFF);
    send_request(OP_UPDATE, -16'sd1, 16'sd0);
  endtask

  // Low limit above high limit in the speed loop.
  task automatic test_inverted_limits();
    wait_drained();
    set_config(1'b0, 16'h1000, 16'h0080, 16'sd1000, -16'sd1000);
    send_request(OP_UPDATE, 16'sd2000, 16'sd0);
    send_request(OP_UPDATE, -16'sd2000, 16'sd0);
    send_request(OP_UPDATE, 16'sd0, 16'sd0);
    send_request(OP_UPDATE, 16'sd0, 16'sd3);
  endtask

  // One gain at zero, then the other: the matching terms vanish.
  task automatic test_zero_gains();
    wait_drained();
    set_config(1'b0, 16'h0000, 16'h1000, -16'sd5, 16'sd5);
    send_request(OP_UPDATE, 16'sd300, 16'sd0);
    send_request(OP_UPDATE, 16'sd300, 16'sd0);
    wait_drained();
    set_config(1'b0, 16'h2000, 16'h0000, -16'sd5, 16'sd5);
    send_request(OP_UPDATE, 16'sd300, 16'sd0);
    send_request(OP_UPDATE, -16'sd1, 16'sd0);
  endtask

  // Random traffic over several register settings. Each phase starts from a
  // drained block, which also pauses the sender until all results are home.
  // The final phase runs with neither side idling.
  task automatic test_random_traffic();
    logic                      op;
    logic signed [SAMPLE_W-1:0] sp, fb;
    for (int phase = 0; phase < 9; phase++) begin
      wait_drained();
      if (phase == 8) bursts_on = 1'b0;
      set_random_config();
      for (int n = 0; n < 110; n++) begin
        op = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_UPDATE;
        sp = pick_sample();
        // Mostly small errors so the loop settles rather than pinning.
        if ($urandom_range(0, 2) == 0) fb = pick_sample();
        else fb = sp + SAMPLE_W'($urandom_range(0, 400)) - 16'd200;
        send_request(op, sp, fb);
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    smp_ch.valid     = 1'b0;
    smp_ch.operation = OP_UPDATE;
    smp_ch.setpoint  = '0;
    smp_ch.feedback  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_CURRENT_MODE;
    cfg_ch.data      = '0;
    res_ch.ready     = 1'b0;
    mode_q     = 1'b0;
    kp_q       = '0;
    ki_q       = '0;
    lo_q       = 16'sh8000;
    hi_q       = 16'sh7FFF;
    integ_acc  = 0;
    excess_acc = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_speed_extremes();
    test_current_mode();
    test_inverted_limits();
    test_zero_gains();
    test_random_traffic();
    wait_drained();

    if (error_count == 0) $display("PASS pi_backcalc_antiwindup");
    else $display("FAIL pi_backcalc_antiwindup");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about 1000 requests.
  initial begin
    #5_000_000;
    $display("FAIL pi_backcalc_antiwindup");
    $finish;
  end

endmodule

[filelist.f]
design/pibc_pkg.sv
design/pibc_ifs.sv
design/pibc_mul.sv
design/pi_backcalc_antiwindup.sv
tb/sv/pi_backcalc_antiwindup_tb.sv
